@@ rtl/core/lfu_cache_with_lru_tiebreak_macros.svh @@
// Assertion macros for the LFU cache.
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define LFU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int unsigned LFU_ENTRIES = 16;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned USES_W = 16;
  localparam int unsigned STAMP_W = 48;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic signed [31:0] read_value;
  } out_item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

@@ rtl/core/lfu_front.sv @@
// ----------------------------------------------------------------------------
// lfu_front
// Input stage and two-entry command queue between the port and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_front
  import lfu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_item
);

  in_item_t  slots [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] fill;
  logic      push;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Queue storage, written on each input transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ rtl/core/lfu_back.sv @@
// ----------------------------------------------------------------------------
// lfu_back
// Scans the entries one per cycle for the key match, the free slot and the
// replacement victim, then updates the chosen entry and presents the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_back
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES = LFU_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] capacity,
  input  logic             q_valid,
  output logic             q_pop,
  input  in_item_t         q_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  output state_t           state_dbg
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid;
  logic [31:0]        keys   [ENTRIES];
  logic [31:0]        values [ENTRIES];
  logic [USES_W-1:0]  uses   [ENTRIES];
  logic [STAMP_W-1:0] stamps [ENTRIES];
  logic [STAMP_W-1:0] counter;

  state_t state, state_next;
  in_item_t cur;
  logic [IW-1:0] idx;
  logic [CW-1:0] count;
  logic found, have_free, have_vic;
  logic [IW-1:0] match, freeslot, victim;
  logic [USES_W-1:0] vic_uses;
  logic [STAMP_W-1:0] vic_stamp;
  logic [31:0] match_val;
  logic [CW-1:0] cap_eff;
  logic last;
  logic better;
  out_item_t res;

  assign state_dbg = state;
  assign last = (idx == IW'(ENTRIES - 1));
  assign cap_eff = (32'(capacity) > ENTRIES) ? CW'(ENTRIES) : CW'(capacity);
  assign better = !have_vic || (uses[idx] < vic_uses) ||
                  ((uses[idx] == vic_uses) && (stamps[idx] < vic_stamp));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = ST_SCAN;
      ST_SCAN:  if (last) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    out_valid = (state == ST_OUT);
    out_item  = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      counter <= '0;
    end else begin
      state <= state_next;
      if (state == ST_WRITE) begin
        counter <= counter + 1'b1;
        if (cur.cmd == CMD_PUT && cap_eff != '0 && !found) begin
          if ((count >= cap_eff && have_vic) || !have_free) begin
            valid[victim] <= 1'b1;
          end else begin
            valid[freeslot] <= 1'b1;
          end
        end
      end
    end
  end

  // Scan bookkeeping and entry payload updates.
  always_ff @(posedge clk) begin
    logic [IW-1:0] slot;
    slot = ((count >= cap_eff && have_vic) || !have_free) ? victim : freeslot;
    unique case (state)
      ST_IDLE: begin
        cur       <= q_item;
        idx       <= '0;
        count     <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
        have_vic  <= 1'b0;
      end
      ST_SCAN: begin
        idx <= idx + 1'b1;
        if (!valid[idx]) begin
          if (!have_free) begin
            have_free <= 1'b1;
            freeslot  <= idx;
          end
        end else begin
          count <= count + 1'b1;
          if (!found && keys[idx] == cur.key) begin
            found     <= 1'b1;
            match     <= idx;
            match_val <= values[idx];
          end
          if (better) begin
            have_vic  <= 1'b1;
            victim    <= idx;
            vic_uses  <= uses[idx];
            vic_stamp <= stamps[idx];
          end
        end
      end
      ST_WRITE: begin
        res.hit        <= 1'b0;
        res.read_value <= MISS_VALUE;
        if (found && (cur.cmd == CMD_GET || cap_eff != '0)) begin
          if (uses[match] != '1) begin
            uses[match] <= uses[match] + 1'b1;
          end
          stamps[match] <= counter;
        end
        if (cur.cmd == CMD_GET) begin
          if (found) begin
            res.hit        <= 1'b1;
            res.read_value <= match_val;
          end
        end else if (cap_eff != '0) begin
          if (found) begin
            values[match] <= cur.value;
          end else begin
            keys[slot]   <= cur.key;
            values[slot] <= cur.value;
            uses[slot]   <= USES_W'(1);
            stamps[slot] <= counter;
          end
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/lfu_cache_with_lru_tiebreak.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak
// Key-value cache with least-frequently-used replacement, ties to the oldest.
// ----------------------------------------------------------------------------
// Each item passes through the back-end states in order: a start state, a scan
// of every entry, one entry per cycle, that finds the key match, the free slot
// and the victim, a write-back state and a result state. A two-item queue
// takes input transfers while the back end works, and the result register
// holds a finished result until it is taken.
`timescale 1ns / 1ps

`include "lfu_cache_with_lru_tiebreak_macros.svh"

module lfu_cache_with_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES = LFU_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  logic [CAP_W-1:0] capacity;
  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;
  state_t   st;
  logic     res_miss;
  logic     res_neg_one;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  lfu_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  lfu_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst(rst), .capacity(capacity), .q_valid(q_valid),
    .q_pop(q_pop), .q_item(q_item), .out_valid(out_valid),
    .out_stall(out_stall), .out_item(out_item), .state_dbg(st)
  );

  // Terms used by the checks below.
  assign res_miss    = out_valid && !out_item.hit;
  assign res_neg_one = (out_item.read_value == MISS_VALUE);

  // A result without a hit reads -1.
  `LFU_ASSERT_IMPL(a_miss_value, clk, rst, res_miss, res_neg_one, "miss must read -1")
  // The queue is only popped while it holds an item.
  `LFU_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, q_valid, "pop from empty queue")
  // A stalled result stays presented.
  `LFU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  // A result is only presented from the output state.
  `LFU_ASSERT_IMPL(a_out_state, clk, rst, out_valid, st == ST_OUT, "result outside output state")

endmodule

@@ tb/tb_lfu_cache_with_lru_tiebreak.sv @@
// ----------------------------------------------------------------------------
// tb_lfu_cache_with_lru_tiebreak
// Self-checking bench for the LFU cache: a directed table of gets and puts
// followed by random traffic over a small key pool, checked against an
// in-bench model of the cache under several capacity settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lfu_cache_with_lru_tiebreak;
  import lfu_pkg::*;

  localparam int NSLOT = 16;
  localparam int DIR_ROWS = 22;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;

  lfu_cache_with_lru_tiebreak dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Model state of the cache.
  int unsigned          cap_m;
  bit                   m_valid [NSLOT];
  bit [31:0]            m_key   [NSLOT];
  bit [31:0]            m_value [NSLOT];
  bit [USES_W-1:0]      m_uses  [NSLOT];
  bit [STAMP_W-1:0]     m_stamp [NSLOT];
  bit [STAMP_W-1:0]     m_clock;

  out_item_t pending_reads[$];
  int        mismatches;

  // Directed table: expected result given only where it is obvious.
  typedef struct {
    cmd_t      op;
    bit [31:0] key;
    bit [31:0] value;
    bit        known;
    bit        exp_hit;
    bit [31:0] exp_val;
  } dir_row_t;

  dir_row_t dir_table[DIR_ROWS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one item and advance the model.
  function automatic out_item_t cache_lookup(cmd_t op, bit [31:0] key, bit [31:0] val);
    out_item_t r;
    int unsigned cap, cnt, victim, freeslot, match, slot;
    bit found, have_free, have_victim;
    cap = (cap_m > NSLOT) ? NSLOT : cap_m;
    cnt = 0; victim = 0; freeslot = 0; match = 0;
    found = 0; have_free = 0; have_victim = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!m_valid[i]) begin
        if (!have_free) begin
          have_free = 1;
          freeslot = i;
        end
      end else begin
        cnt++;
        if (!found && m_key[i] == key) begin
          found = 1;
          match = i;
        end
        if (!have_victim || m_uses[i] < m_uses[victim] ||
            (m_uses[i] == m_uses[victim] && m_stamp[i] < m_stamp[victim])) begin
          have_victim = 1;
          victim = i;
        end
      end
    end
    r.hit = 1'b0;
    r.read_value = MISS_VALUE;
    if (op == CMD_GET) begin
      if (found) begin
        r.hit = 1'b1;
        r.read_value = m_value[match];
        if (m_uses[match] != '1) m_uses[match]++;
        m_stamp[match] = m_clock;
      end
    end else if (cap != 0) begin
      if (found) begin
        m_value[match] = val;
        if (m_uses[match] != '1) m_uses[match]++;
        m_stamp[match] = m_clock;
      end else begin
        if (cnt >= cap && have_victim) slot = victim;
        else if (have_free) slot = freeslot;
        else slot = victim;
        m_valid[slot] = 1;
        m_key[slot] = key;
        m_value[slot] = val;
        m_uses[slot] = 1;
        m_stamp[slot] = m_clock;
      end
    end
    m_clock = m_clock + 1'b1;
    return r;
  endfunction

  // Present one item and wait for its transfer.
  task automatic send_item(cmd_t op, bit [31:0] key, bit [31:0] val);
    out_item_t r;
    in_valid <= 1'b1;
    in_item.cmd <= op;
    in_item.key <= key;
    in_item.value <= val;
    do @(posedge clk); while (in_stall);
    r = cache_lookup(op, key, val);
    pending_reads.push_back(r);
    @(negedge clk);
  endtask

  // Random burst pacing between items.
  int burst_left;
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Wait for every expected result, then for the back end to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_capacity(int unsigned c);
    cfg_we <= 1'b1;
    cfg_data <= c[CAP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_m = c;
  endtask

  // Receiver stall pattern: mixes free runs with heavy stalling.
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: hit=%0b value=%h",
                                       out_item.hit, out_item.read_value);
      end else begin
        e = pending_reads[0];
        pending_reads.delete(0);
        if (out_item.hit !== e.hit || out_item.read_value !== e.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                     e.hit, e.read_value, out_item.hit, out_item.read_value);
        end
      end
    end
  end

  // Random phase: small key pool so hits and evictions are common.
  task automatic random_phase(int n);
    bit [31:0] key, val;
    cmd_t op;
    for (int i = 0; i < n; i++) begin
      pace();
      op = ($urandom_range(0, 1) != 0) ? CMD_PUT : CMD_GET;
      if ($urandom_range(0, 9) == 0) key = $urandom();
      else key = $urandom_range(0, 23) ^ (($urandom_range(0, 7) == 0) ? 32'h8000_0000 : 0);
      val = $urandom();
      send_item(op, key, val);
    end
  endtask

  initial begin
    out_item_t r;
    // Directed rows: fill, hit, update, eviction, extremes of key and value.
    dir_table[0]  = '{CMD_GET, 32'h0, 32'h0, 1, 0, MISS_VALUE};
    dir_table[1]  = '{CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, MISS_VALUE};
    dir_table[2]  = '{CMD_GET, 32'h8000_0000, 32'h0, 1, 1, 32'h7FFF_FFFF};
    dir_table[3]  = '{CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, MISS_VALUE};
    dir_table[4]  = '{CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000};
    dir_table[5]  = '{CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, MISS_VALUE};
    dir_table[6]  = '{CMD_GET, 32'hFFFF_FFFF, 32'h0, 1, 1, 32'hFFFF_FFFF};
    dir_table[7]  = '{CMD_PUT, 32'h8000_0000, 32'h0, 1, 0, MISS_VALUE};
    dir_table[8]  = '{CMD_GET, 32'h8000_0000, 32'h0, 1, 1, 32'h0};
    dir_table[9]  = '{CMD_GET, 32'h1, 32'h0, 1, 0, MISS_VALUE};
    for (int i = 10; i < DIR_ROWS; i++)
      dir_table[i] = '{CMD_PUT, i, 32'h5A5A_0000 + i, 0, 0, 0};
    dir_table[20] = '{CMD_GET, 32'h7FFF_FFFF, 32'h0, 0, 0, 0};
    dir_table[21] = '{CMD_GET, 32'h0000_000A, 32'h0, 0, 0, 0};

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    mismatches = 0;
    burst_left = 0;
    cap_m = CAP_RESET;
    m_clock = '0;
    foreach (m_valid[i]) begin
      m_valid[i] = 0; m_key[i] = 0; m_value[i] = 0; m_uses[i] = 0; m_stamp[i] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at capacity 3 so the table rows evict.
    write_capacity(3);
    foreach (dir_table[i]) begin
      pace();
      if (dir_table[i].known) begin
        r = cache_lookup(dir_table[i].op, dir_table[i].key, dir_table[i].value);
        if (r.hit !== dir_table[i].exp_hit || r.read_value !== dir_table[i].exp_val) begin
          mismatches++;
          if (mismatches <= 10) $display("Directed row %0d disagrees with bench model", i);
        end
        // The model has already taken this item, so the typed result is queued.
        in_valid <= 1'b1;
        in_item.cmd <= dir_table[i].op;
        in_item.key <= dir_table[i].key;
        in_item.value <= dir_table[i].value;
        do @(posedge clk); while (in_stall);
        pending_reads.push_back('{dir_table[i].exp_hit, dir_table[i].exp_val});
        @(negedge clk);
      end else begin
        send_item(dir_table[i].op, dir_table[i].key, dir_table[i].value);
      end
    end
    drain();

    // Capacity zero: puts are ignored, gets still search.
    write_capacity(0);
    random_phase(40);
    drain();
    write_capacity(1);
    random_phase(80);
    drain();
    write_capacity(31);
    random_phase(250);
    drain();
    write_capacity(5);
    random_phase(200);
    drain();
    write_capacity(16);
    random_phase(180);
    drain();

    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
